FILE: src/mf3_pkg.sv
// Shared types, constants and compare helpers for the 3x3 median filter.
// Depends on nothing; imported by the top level, the checker and the testbench.
package mf3_pkg;

   // Pixel and register widths
   localparam int PIX_W         = 8;
   localparam int WIDTH_REG_W   = 13;
   localparam int HEIGHT_REG_W  = 16;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_INDEX_W   = 2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   // Register reset values
   localparam int WIDTH_RESET  = 2048;
   localparam int HEIGHT_RESET = 1024;

   // Smallest frame edge
   localparam int MIN_EDGE = 3;

   // Result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = 3;
   localparam int FIFO_CW    = 4;

   typedef logic [PIX_W-1:0] pixel_type;

   // Sideband that follows a transaction down the pipeline
   typedef struct packed {
      logic emit;   // this input releases a result
      logic med;    // result is the window median
      logic fend;   // result closes the frame
   } mf3_ctl_type;

   typedef struct packed {
      pixel_type hi;
      pixel_type md;
      pixel_type lo;
   } mf3_trio_type;

   typedef struct packed {
      pixel_type pixel;
      logic      fend;
   } mf3_result_type;

   function automatic pixel_type max2(input pixel_type a, input pixel_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic pixel_type min2(input pixel_type a, input pixel_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pixel_type med3(input pixel_type a, input pixel_type b,
                                      input pixel_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   function automatic mf3_trio_type sort3(input pixel_type a, input pixel_type b,
                                          input pixel_type c);
      mf3_trio_type t;
      t.hi = max2(max2(a, b), c);
      t.lo = min2(min2(a, b), c);
      t.md = med3(a, b, c);
      return t;
   endfunction

endpackage

FILE: src/mf3_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module mf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/median_filter_3x3_unit.sv
// A result passes stage 1, the window, stages 3 and 4 and the result queue to rsp.
// Throughput: one pixel per clock unless req is stalled; the line stores are read
// at accept and written back in the next cycle, so every accept starts one read-modify-write pair.
// The output lags the frame by one row and one pixel; stall on rsp fills an
// eight-entry result queue before req is stalled.
// Reset (synchronous): 2048 x 1024 size, counters cleared, queue emptied.
module median_filter_3x3_unit
   import mf3_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   // input channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PIX_W-1:0]       req_pixel_in,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PIX_W-1:0]       rsp_pixel_out,
   output logic                   rsp_last_of_run,
   output logic                   rsp_frame_end,
   // configuration
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam logic [16:0] MAX_W17 = 17'(MAX_WIDTH);
   localparam int WIDTH_RST_EFF = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
   localparam logic [AW-1:0] COL_LAST_RST = AW'(WIDTH_RST_EFF - 1);
   localparam logic [HEIGHT_REG_W-1:0] ROW_LAST_RST = HEIGHT_REG_W'(HEIGHT_RESET - 1);

   logic req_accept;
   logic rsp_accept;

   // ---------------- configuration ----------------
   logic                    cfg_width_wr, cfg_height_wr, cfg_any_wr;
   logic [16:0]             width_req, width_eff;
   logic [HEIGHT_REG_W-1:0] height_req;
   logic [AW-1:0]           col_last_ff, col_last_in;
   logic [HEIGHT_REG_W-1:0] row_last_ff, row_last_in;

   assign cfg_width_wr  = csr_wr_en && (csr_index == CSR_IMAGE_WIDTH);
   assign cfg_height_wr = csr_wr_en && (csr_index == CSR_IMAGE_HEIGHT);
   assign cfg_any_wr    = cfg_width_wr || cfg_height_wr;

   // Clamp the written sizes and keep the last column and row index
   always_comb begin
      width_req  = {4'd0, csr_wr_data[WIDTH_REG_W-1:0]};
      height_req = csr_wr_data[HEIGHT_REG_W-1:0];
      priority if (width_req < 17'(MIN_EDGE)) begin
         width_eff = 17'(MIN_EDGE);
      end else if (width_req > MAX_W17) begin
         width_eff = MAX_W17;
      end else begin
         width_eff = width_req;
      end
      col_last_in = cfg_width_wr ? AW'(width_eff - 17'd1) : col_last_ff;
      row_last_in = row_last_ff;
      if (cfg_height_wr) begin
         row_last_in = (height_req < HEIGHT_REG_W'(MIN_EDGE)) ?
                       HEIGHT_REG_W'(MIN_EDGE - 1) : height_req - 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_last_ff <= COL_LAST_RST;
         row_last_ff <= ROW_LAST_RST;
      end else begin
         col_last_ff <= col_last_in;
         row_last_ff <= row_last_in;
      end
   end

   // ---------------- raster position ----------------
   logic [AW-1:0]           col_ff, col_in;
   logic [HEIGHT_REG_W-1:0] row_ff, row_in;
   logic                    have_prev_ff, have_prev_in;
   mf3_ctl_type             acc_ctl;
   logic                    col_zero, row_ge1, row_ge2;

   // Classify the transaction by where it lands in the frame
   always_comb begin
      col_zero     = (col_ff == '0);
      row_ge1      = (row_ff != '0);
      row_ge2      = (row_ff[HEIGHT_REG_W-1:1] != '0);
      acc_ctl.emit = col_zero ? (row_ge2 || have_prev_ff) : (row_ge1 || have_prev_ff);
      acc_ctl.med  = !col_zero && row_ge2 && (col_ff[AW-1:1] != '0);
      acc_ctl.fend = col_zero && (row_ff == HEIGHT_REG_W'(1));
   end

   // Advance column, row and frame on accept; restart on a register write
   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      have_prev_in = have_prev_ff;
      priority if (cfg_any_wr) begin
         col_in       = '0;
         row_in       = '0;
         have_prev_in = 1'b0;
      end else if (req_accept) begin
         if (col_ff == col_last_ff) begin
            col_in = '0;
            if (row_ff == row_last_ff) begin
               row_in       = '0;
               have_prev_in = 1'b1;
            end else begin
               row_in = row_ff + 16'd1;
            end
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         have_prev_ff <= have_prev_in;
      end
   end

   // ---------------- line stores ----------------
   logic            p1_valid_ff;
   mf3_ctl_type     p1_ctl_ff;
   pixel_type       p1_px_ff;
   logic [AW-1:0]   p1_addr_ff;
   pixel_type       up_rd, mid_rd;

   // Upper row takes the old middle word, middle row takes the new pixel
   mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_upper (
      .clock   (clock),
      .wr_en   (p1_valid_ff),
      .wr_addr (p1_addr_ff),
      .wr_data (mid_rd),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (up_rd)
   );

   mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_middle (
      .clock   (clock),
      .wr_en   (p1_valid_ff),
      .wr_addr (p1_addr_ff),
      .wr_data (p1_px_ff),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (mid_rd)
   );

   // Stage 1: transaction waits for the line store read
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p1_ctl_ff   <= '0;
      end else begin
         p1_valid_ff <= req_accept;
         p1_ctl_ff   <= req_accept ? acc_ctl : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         p1_px_ff   <= req_pixel_in;
         p1_addr_ff <= col_ff;
      end
   end

   // ---------------- window ----------------
   pixel_type   win_ff [3][3];   // [row][column], column 2 newest
   mf3_ctl_type p2_ctl_ff;
   pixel_type   p2_byp_ff;

   // Shift the window left and load the new column
   always_ff @(posedge clock) begin
      if (p1_valid_ff) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k][0] <= win_ff[k][1];
            win_ff[k][1] <= win_ff[k][2];
         end
         win_ff[0][2] <= up_rd;
         win_ff[1][2] <= mid_rd;
         win_ff[2][2] <= p1_px_ff;
         p2_byp_ff    <= win_ff[1][2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_ctl_ff <= '0;
      end else begin
         p2_ctl_ff <= p1_ctl_ff;
      end
   end

   // ---------------- median network ----------------
   mf3_trio_type p3_col_ff [3];
   mf3_ctl_type  p3_ctl_ff;
   pixel_type    p3_byp_ff;
   pixel_type    p4_lo_ff, p4_md_ff, p4_hi_ff;
   mf3_ctl_type  p4_ctl_ff;
   pixel_type    p4_byp_ff;
   pixel_type    med_result;

   // Stage 3: sort each column
   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         p3_col_ff[j] <= sort3(win_ff[0][j], win_ff[1][j], win_ff[2][j]);
      end
      p3_byp_ff <= p2_byp_ff;
   end

   // Stage 4: largest low, middle median, smallest high
   always_ff @(posedge clock) begin
      p4_lo_ff  <= max2(max2(p3_col_ff[0].lo, p3_col_ff[1].lo), p3_col_ff[2].lo);
      p4_md_ff  <= med3(p3_col_ff[0].md, p3_col_ff[1].md, p3_col_ff[2].md);
      p4_hi_ff  <= min2(min2(p3_col_ff[0].hi, p3_col_ff[1].hi), p3_col_ff[2].hi);
      p4_byp_ff <= p3_byp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_ctl_ff <= '0;
         p4_ctl_ff <= '0;
      end else begin
         p3_ctl_ff <= p2_ctl_ff;
         p4_ctl_ff <= p3_ctl_ff;
      end
   end

   assign med_result = p4_ctl_ff.med ? med3(p4_lo_ff, p4_md_ff, p4_hi_ff) : p4_byp_ff;

   // ---------------- result queue ----------------
   mf3_result_type       fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]   count_ff, count_in;
   logic [FIFO_CW:0]     outstanding;
   logic                 push;

   assign push       = p4_ctl_ff.emit;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= '{pixel: med_result, fend: p4_ctl_ff.fend};
      end
   end

   // Move pointers and fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = rsp_accept ? rd_ptr_ff + FIFO_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + FIFO_CW'(push) - FIFO_CW'(rsp_accept);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold req while queued plus in-flight results could fill the queue
   assign outstanding = {1'b0, count_ff} + (FIFO_CW+1)'(p1_ctl_ff.emit)
                      + (FIFO_CW+1)'(p2_ctl_ff.emit) + (FIFO_CW+1)'(p3_ctl_ff.emit)
                      + (FIFO_CW+1)'(p4_ctl_ff.emit);
   assign req_stall   = (outstanding >= (FIFO_CW+1)'(FIFO_DEPTH));

   assign rsp_valid       = (count_ff != '0);
   assign rsp_pixel_out   = fifo_ff[rd_ptr_ff].pixel;
   assign rsp_frame_end   = fifo_ff[rd_ptr_ff].fend;
   assign rsp_last_of_run = 1'b1;

endmodule

FILE: src/mf3_checker.sv
// Port-level checks for the 3x3 median filter, bound to the top level.
// Depends on mf3_pkg and median_filter_3x3_unit.
module mf3_checker
   import mf3_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [PIX_W-1:0] rsp_pixel_out,
   input logic             rsp_last_of_run,
   input logic             rsp_frame_end
);

   // A stalled result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_out)
                                 && $stable(rsp_frame_end))
      else $error("result changed while stalled");

   // Every input releases at most one result, so each result closes its run
   a_run_closed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last_of_run)
      else $error("result not marked last of run");

   // Reset empties the result queue
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // Reset leaves the block ready for input
   a_reset_ready: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled after reset");

endmodule

bind median_filter_3x3_unit mf3_checker u_mf3_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_pixel_out   (rsp_pixel_out),
   .rsp_last_of_run (rsp_last_of_run),
   .rsp_frame_end   (rsp_frame_end)
);

FILE: sim/tb_median_filter_3x3_unit.sv
// Self-checking testbench for median_filter_3x3_unit: streams greyscale frames
// and checks every filtered pixel against an in-bench predictor of the filter.
// Depends on mf3_pkg and the top level in src/.
`timescale 1ns / 1ps

module tb_median_filter_3x3_unit
   import mf3_pkg::*;
();

   localparam int LINE_DEPTH    = 4096;
   localparam int SETTLE_CYCLES = 10;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int REPORT_MAX    = 10;
   localparam int RANDOM_ITEMS  = 300;
   localparam int WIDE_ITEMS    = 40;

   // Indexes outside the register map, written to check that they are ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef enum int {CONTENT_UNIFORM, CONTENT_BINARY, CONTENT_NARROW} content_mode_type;
   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_LONG} stall_mode_type;

   typedef struct packed {
      pixel_type pixel;
      logic      last;
      logic      fend;
   } filtered_pixel_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [PIX_W-1:0]       req_pixel_in;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [PIX_W-1:0]       rsp_pixel_out;
   logic                   rsp_last_of_run;
   logic                   rsp_frame_end;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   // Filter predictor state
   logic [WIDTH_REG_W-1:0]  width_setting;
   logic [HEIGHT_REG_W-1:0] height_setting;
   pixel_type               upper_line [LINE_DEPTH];
   pixel_type               middle_line [LINE_DEPTH];
   pixel_type               window_px [3][3];
   int unsigned             col_pos;
   int unsigned             row_pos;
   bit                      frame_taken;

   filtered_pixel_type filtered_queue [$];
   int                 error_count;
   int                 cycle_count;
   int                 burst_left;

   median_filter_3x3_unit #(.MAX_WIDTH(LINE_DEPTH)) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_in    (req_pixel_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_end   (rsp_frame_end),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Frame size as the block uses it, clamped to what the line stores hold
   function automatic int unsigned effective_width();
      if (width_setting < MIN_EDGE) return MIN_EDGE;
      if (width_setting > LINE_DEPTH) return LINE_DEPTH;
      return width_setting;
   endfunction

   function automatic int unsigned effective_height();
      return (height_setting < MIN_EDGE) ? MIN_EDGE : height_setting;
   endfunction

   function automatic void restart_stream();
      col_pos     = 0;
      row_pos     = 0;
      frame_taken = 1'b0;
   endfunction

   function automatic void clear_filter_state();
      width_setting  = WIDTH_REG_W'(WIDTH_RESET);
      height_setting = HEIGHT_REG_W'(HEIGHT_RESET);
      for (int i = 0; i < LINE_DEPTH; i++) begin
         upper_line[i]  = '0;
         middle_line[i] = '0;
      end
      for (int k = 0; k < 9; k++) window_px[k / 3][k % 3] = '0;
      restart_stream();
   endfunction

   function automatic pixel_type window_median();
      pixel_type v [9];
      pixel_type key;
      int        j;
      for (int i = 0; i < 9; i++) v[i] = window_px[i / 3][i % 3];
      for (int i = 1; i < 9; i++) begin
         key = v[i];
         j   = i;
         while (j > 0 && v[j - 1] > key) begin
            v[j] = v[j - 1];
            j--;
         end
         v[j] = key;
      end
      return v[4];
   endfunction

   // Advance the filter by one raw pixel and queue the pixel it releases, if any
   function automatic void filter_pixel(input pixel_type px);
      int unsigned        w, h, c, r;
      pixel_type          up, mid;
      filtered_pixel_type res;
      bit                 emit;
      w    = effective_width();
      h    = effective_height();
      c    = (col_pos >= w) ? 0 : col_pos;
      r    = (row_pos >= h) ? 0 : row_pos;
      emit = 1'b0;
      res  = '0;
      res.last = 1'b1;
      // right border pixel of the row two rows back
      if (c == 0 && (r >= 2 || frame_taken)) begin
         res.pixel = window_px[1][2];
         res.fend  = (r == 1);
         emit      = 1'b1;
      end
      up  = upper_line[c];
      mid = middle_line[c];
      upper_line[c]  = mid;
      middle_line[c] = px;
      for (int k = 0; k < 3; k++) begin
         window_px[k][0] = window_px[k][1];
         window_px[k][1] = window_px[k][2];
      end
      window_px[0][2] = up;
      window_px[1][2] = mid;
      window_px[2][2] = px;
      // window centre: median for interior pixels, raw on the border
      if (c != 0 && (r >= 1 || frame_taken)) begin
         res.pixel = (r >= 2 && c >= 2) ? window_median() : window_px[1][1];
         emit      = 1'b1;
      end
      if (emit) filtered_queue.push_back(res);
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) begin
            r = 0;
            frame_taken = 1'b1;
         end
      end
      col_pos = c;
      row_pos = r;
   endfunction

   function automatic pixel_type random_pixel(input content_mode_type mode,
                                              input pixel_type base);
      case (mode)
         CONTENT_BINARY: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         CONTENT_NARROW: return base ^ pixel_type'($urandom_range(0, 3));
         default:        return pixel_type'($urandom_range(0, 255));
      endcase
   endfunction

   // Send one pixel transaction, with burst gaps, and predict its results
   task automatic send_pixel(input pixel_type px);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(32, 96);
         end else begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
         end
      end
      burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      filter_pixel(px);
      @(negedge clock);
   endtask

   // Hold the input idle until every queued pixel has come, then let the pipe settle
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (filtered_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH: begin
            width_setting = data[WIDTH_REG_W-1:0];
            restart_stream();
         end
         CSR_IMAGE_HEIGHT: begin
            height_setting = data;
            restart_stream();
         end
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Sizes below 3x3 clamp up; a full frame, then the tail released by the next one
   task automatic test_small_frame();
      pixel_type frame_a [9] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
                                 8'h80, 8'h01, 8'hFE};
      pixel_type frame_b [4] = '{8'h7F, 8'h55, 8'hAA, 8'hFF};
      write_register(CSR_IMAGE_WIDTH, 16'd1);
      write_register(CSR_IMAGE_HEIGHT, 16'd2);
      foreach (frame_a[i]) send_pixel(frame_a[i]);
      foreach (frame_b[i]) send_pixel(frame_b[i]);
   endtask

   // Pause until the queue is empty, write unmapped indexes, and carry on the frame
   task automatic test_unknown_index();
      pixel_type rest [6] = '{8'h00, 8'hFF, 8'h10, 8'hEF, 8'h00, 8'hFF};
      wait_results_drained();
      write_register(CSR_SPARE_A, 16'hFFFF);
      write_register(CSR_SPARE_B, 16'hFFFF);
      foreach (rest[i]) send_pixel(rest[i]);
   endtask

   // Width written with every bit set masks to 8191 and clamps to the line store size;
   // stream part of the first row, which releases nothing while the window primes
   task automatic test_widest_frame();
      wait_results_drained();
      write_register(CSR_IMAGE_WIDTH, 16'hFFFF);
      write_register(CSR_IMAGE_HEIGHT, 16'd0);
      repeat (WIDE_ITEMS) send_pixel(random_pixel(CONTENT_UNIFORM, 8'h00));
   endtask

   task automatic test_tallest_setting();
      wait_results_drained();
      write_register(CSR_IMAGE_HEIGHT, 16'hFFFF);
      write_register(CSR_IMAGE_WIDTH, 16'd3);
      repeat (30) send_pixel(random_pixel(CONTENT_UNIFORM, 8'h00));
   endtask

   // Random sizes and content; one to three whole frames back to back, cut off at a random point
   task automatic test_random_frames();
      int                    sent_items;
      int unsigned           ew, eh, count;
      logic [CSR_DATA_W-1:0] w_data, h_data;
      content_mode_type      mode;
      pixel_type             base;
      sent_items = 0;
      while (sent_items < RANDOM_ITEMS) begin
         wait_results_drained();
         w_data = ($urandom_range(0, 7) == 0) ? CSR_DATA_W'($urandom_range(0, 2))
                                               : CSR_DATA_W'($urandom_range(3, 9));
         if ($urandom_range(0, 7) == 0) w_data[15:13] = 3'($urandom_range(1, 7));
         h_data = ($urandom_range(0, 7) == 0) ? CSR_DATA_W'($urandom_range(0, 2))
                                               : CSR_DATA_W'($urandom_range(3, 6));
         case ($urandom_range(0, 3))
            0: write_register(CSR_IMAGE_WIDTH, w_data);
            1: write_register(CSR_IMAGE_HEIGHT, h_data);
            2: begin
               write_register(CSR_IMAGE_HEIGHT, h_data);
               write_register(CSR_IMAGE_WIDTH, w_data);
            end
            default: begin
               write_register(CSR_IMAGE_WIDTH, w_data);
               write_register(CSR_IMAGE_HEIGHT, h_data);
            end
         endcase
         ew    = effective_width();
         eh    = effective_height();
         count = $urandom_range(1, 3) * ew * eh + $urandom_range(0, ew * eh - 1);
         mode  = content_mode_type'($urandom_range(0, 2));
         base  = pixel_type'($urandom_range(0, 255));
         repeat (count) send_pixel(random_pixel(mode, base));
         sent_items += count;
      end
   endtask

   // Receiver stall pattern: free-running, random, or long stall runs
   initial begin
      stall_mode_type mode;
      int             mode_left;
      int             hold;
      rsp_stall = 1'b0;
      mode      = STALL_NONE;
      mode_left = 0;
      hold      = 0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(40, 300);
         end
         mode_left--;
         case (mode)
            STALL_RANDOM: rsp_stall <= ($urandom_range(0, 1) != 0);
            STALL_LONG: begin
               if (hold > 0) begin
                  hold--;
                  rsp_stall <= 1'b1;
               end else begin
                  rsp_stall <= 1'b0;
                  hold = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
               end
            end
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   // Compare each result transaction with the oldest queued pixel
   always @(posedge clock) begin
      filtered_pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (filtered_queue.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_MAX)
               $display("unexpected result: pixel %0d last %0b end %0b",
                        rsp_pixel_out, rsp_last_of_run, rsp_frame_end);
         end else begin
            want = filtered_queue.pop_front();
            if (rsp_pixel_out !== want.pixel || rsp_last_of_run !== want.last ||
                rsp_frame_end !== want.fend) begin
               error_count++;
               if (error_count <= REPORT_MAX)
                  $display({"mismatch: expected pixel %0d last %0b end %0b, ",
                            "got pixel %0d last %0b end %0b"},
                           want.pixel, want.last, want.fend,
                           rsp_pixel_out, rsp_last_of_run, rsp_frame_end);
            end
         end
      end
   end

   // Guard against a hung pipeline
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_pixel_in = '0;
      csr_wr_en    = 1'b0;
      csr_index    = '0;
      csr_wr_data  = '0;
      error_count  = 0;
      cycle_count  = 0;
      burst_left   = 0;
      clear_filter_state();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_small_frame();
      test_unknown_index();
      test_widest_frame();
      test_tallest_setting();
      test_random_frames();
      wait_results_drained();

      if (error_count == 0 && filtered_queue.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
